### sv/lbc_pkg.sv
package lbc_pkg;

  // Default pool size
  localparam int NUM_BUFFERS_DEF = 32;

  // Request modes
  localparam logic [2:0] MODE_ACQUIRE = 3'd0;
  localparam logic [2:0] MODE_WRITE   = 3'd1;
  localparam logic [2:0] MODE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_PIN     = 3'd3;
  localparam logic [2:0] MODE_UNPIN   = 3'd4;

  // Disk request codes
  localparam logic [1:0] DREQ_NONE  = 2'd0;
  localparam logic [1:0] DREQ_READ  = 2'd1;
  localparam logic [1:0] DREQ_WRITE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOFREE    = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
  } lbc_req_t;

  typedef struct packed {
    logic [4:0] result_index;
    logic       hit;
    logic [1:0] disk_request;
    logic [1:0] status;
  } lbc_res_t;

  // One buffer's tag, reference count and contents mark
  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] blk_num;
    logic [7:0]  count;
    logic        valid;
  } lbc_entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACQ_WR,
    S_ENT_WR,
    S_SH_RD,
    S_SH_WR,
    S_SH_HEAD,
    S_DONE
  } lbc_state_t;

  // What the shared compare unit looks for during a scan
  typedef enum logic [1:0] {
    SCAN_TAG,
    SCAN_FREE,
    SCAN_POS
  } lbc_scan_kind_t;

endpackage

### sv/lbc_if.sv
interface lbc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  buffer_index;

  modport source (output valid, mode, device, block_number, buffer_index, input ready);
  modport sink   (input valid, mode, device, block_number, buffer_index, output ready);
endinterface

interface lbc_res_if;
  logic       valid;
  logic       ready;
  logic [4:0] result_index;
  logic       hit;
  logic [1:0] disk_request;
  logic [1:0] status;

  modport source (output valid, result_index, hit, disk_request, status, input ready);
  modport sink   (input valid, result_index, hit, disk_request, status, output ready);
endinterface

### sv/lbc_match.sv
module lbc_match #(
  parameter int NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF
) (
  input  lbc_pkg::lbc_scan_kind_t        kind,
  input  lbc_pkg::lbc_entry_t            ent,
  input  logic [$clog2(NUM_BUFFERS)-1:0] idx,
  input  logic [$clog2(NUM_BUFFERS)-1:0] target,
  input  logic [7:0]                     device,
  input  logic [31:0]                    block_number,
  output logic                           match
);
  import lbc_pkg::*;

  // Shared compare: tag equality, free buffer, or list position of a buffer
  always_comb begin
    unique case (kind)
      SCAN_TAG:  match = (ent.device == device) && (ent.blk_num == block_number);
      SCAN_FREE: match = (ent.count == 8'd0);
      SCAN_POS:  match = (idx == target);
      default:   match = 1'b0;
    endcase
  end

endmodule

### sv/lbc_ctrl.sv
module lbc_ctrl #(
  parameter int NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbc_pkg::lbc_req_t in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output lbc_pkg::lbc_res_t out_res
);
  import lbc_pkg::*;

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam logic [IW-1:0] LAST_POS = IW'(NUM_BUFFERS - 1);

  // Tag/count memory by buffer, recency memory by list position (0 = most recent)
  lbc_entry_t    ent_mem [NUM_BUFFERS];
  logic [IW-1:0] rec_mem [NUM_BUFFERS];

  lbc_state_t     state, state_next;
  lbc_scan_kind_t kind;
  lbc_req_t       rq;
  lbc_res_t       res;
  lbc_entry_t     ent_q, fent, ent_wdata;
  logic [IW-1:0]  rec_q;
  logic [IW-1:0]  rec_raddr, rec_waddr, rec_wdata, ent_raddr, ent_waddr;
  logic           rec_we, ent_we;
  logic [IW-1:0]  clr_pos, issue_pos, sh_pos, fidx;
  logic           issue_done;
  logic           v1, last1, v2, last2;
  logic [IW-1:0]  pos1, idx2, pos2;
  logic           match, s2_hit, s2_end;
  logic           in_range, named_rmw;
  logic [IW-1:0]  target;
  logic [IW-1:0]  end_pos;

  assign target   = IW'(rq.buffer_index);
  assign in_range = 32'(in_req.buffer_index) < NUM_BUFFERS;
  assign named_rmw = in_range && ((in_req.mode == MODE_RELEASE) ||
                     (in_req.mode == MODE_PIN) || (in_req.mode == MODE_UNPIN));
  assign end_pos  = (kind == SCAN_FREE) ? '0 : LAST_POS;
  assign s2_hit   = v2 && match;
  assign s2_end   = v2 && last2 && !match;
  assign out_res  = res;

  lbc_match #(.NUM_BUFFERS(NUM_BUFFERS)) u_match (
    .kind         (kind),
    .ent          (ent_q),
    .idx          (idx2),
    .target       (target),
    .device       (rq.device),
    .block_number (rq.block_number),
    .match        (match)
  );

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
    ent_q <= ent_mem[ent_raddr];
    rec_q <= rec_mem[rec_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // Next state, memory ports and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    rec_raddr  = issue_pos;
    ent_raddr  = rec_q;
    rec_we     = 1'b0;
    rec_waddr  = '0;
    rec_wdata  = '0;
    ent_we     = 1'b0;
    ent_waddr  = fidx;
    ent_wdata  = fent;
    unique case (state)
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_waddr = clr_pos;
        rec_wdata = LAST_POS - clr_pos;
        ent_we    = 1'b1;
        ent_waddr = clr_pos;
        ent_wdata = '0;
        if (clr_pos == LAST_POS) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        ent_raddr = IW'(in_req.buffer_index);
        if (in_valid) begin
          if (in_req.mode == MODE_ACQUIRE) state_next = S_SCAN;
          else if (named_rmw)              state_next = S_ENT_WR;
          else                             state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (s2_hit) begin
          if (kind != SCAN_POS)   state_next = S_ACQ_WR;
          else if (pos2 == '0)    state_next = S_DONE;
          else                    state_next = S_SH_RD;
        end else if (s2_end && kind != SCAN_TAG) begin
          state_next = S_DONE;
        end
      end
      S_ACQ_WR: begin
        ent_we          = 1'b1;
        ent_wdata.valid = 1'b1;
        if (kind == SCAN_TAG) begin
          if (fent.count != COUNT_MAX) ent_wdata.count = fent.count + 8'd1;
        end else begin
          ent_wdata.device  = rq.device;
          ent_wdata.blk_num = rq.block_number;
          ent_wdata.count   = 8'd1;
        end
        state_next = S_DONE;
      end
      S_ENT_WR: begin
        ent_waddr = target;
        ent_wdata = ent_q;
        if (rq.mode == MODE_PIN) begin
          ent_we = (ent_q.count != COUNT_MAX);
          ent_wdata.count = ent_q.count + 8'd1;
          state_next = S_DONE;
        end else if (ent_q.count == 8'd0) begin
          state_next = S_DONE;
        end else begin
          ent_we = 1'b1;
          ent_wdata.count = ent_q.count - 8'd1;
          if (rq.mode == MODE_RELEASE && ent_q.count == 8'd1) state_next = S_SCAN;
          else                                                  state_next = S_DONE;
        end
      end
      S_SH_RD: begin
        rec_raddr  = sh_pos - 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        rec_we     = 1'b1;
        rec_waddr  = sh_pos;
        rec_wdata  = rec_q;
        rec_raddr  = sh_pos - IW'(2);
        if (sh_pos == IW'(1)) state_next = S_SH_HEAD;
      end
      S_SH_HEAD: begin
        rec_we     = 1'b1;
        rec_waddr  = '0;
        rec_wdata  = target;
        state_next = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath: scan pipeline, found buffer, pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_pos <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      unique case (state)
        S_CLEAR: clr_pos <= clr_pos + 1'b1;
        S_IDLE: begin
          if (in_valid) begin
            rq                 <= in_req;
            res.result_index   <= in_req.buffer_index;
            res.hit            <= 1'b0;
            res.status         <= STAT_OK;
            res.disk_request   <= (in_req.mode == MODE_WRITE && in_range) ?
                                  DREQ_WRITE : DREQ_NONE;
            kind               <= SCAN_TAG;
            issue_pos          <= '0;
            issue_done         <= 1'b0;
          end
        end
        S_SCAN: begin
          // issue a list read, then an entry read, then compare
          if (!issue_done) begin
            v1    <= 1'b1;
            pos1  <= issue_pos;
            last1 <= (issue_pos == end_pos);
            if (issue_pos == end_pos)   issue_done <= 1'b1;
            else if (kind == SCAN_FREE) issue_pos  <= issue_pos - 1'b1;
            else                        issue_pos  <= issue_pos + 1'b1;
          end
          v2    <= v1;
          idx2  <= rec_q;
          pos2  <= pos1;
          last2 <= last1;
          if (s2_hit) begin
            v1     <= 1'b0;
            v2     <= 1'b0;
            fidx   <= idx2;
            fent   <= ent_q;
            sh_pos <= pos2;
            if (kind != SCAN_POS) begin
              res.result_index <= 5'(idx2);
              res.hit          <= (kind == SCAN_TAG);
              res.disk_request <= (kind == SCAN_FREE || !ent_q.valid) ?
                                  DREQ_READ : DREQ_NONE;
            end
          end else if (s2_end) begin
            v1 <= 1'b0;
            v2 <= 1'b0;
            if (kind == SCAN_TAG) begin
              // miss: look for the least recent free buffer
              kind       <= SCAN_FREE;
              issue_pos  <= LAST_POS;
              issue_done <= 1'b0;
            end else if (kind == SCAN_FREE) begin
              res.result_index <= '0;
              res.hit          <= 1'b0;
              res.disk_request <= DREQ_NONE;
              res.status       <= STAT_NOFREE;
            end
          end
        end
        S_ENT_WR: begin
          if (rq.mode != MODE_PIN && ent_q.count == 8'd0) begin
            res.status <= STAT_UNDERFLOW;
          end else if (rq.mode == MODE_RELEASE && ent_q.count == 8'd1) begin
            // count reaches zero: find the buffer's list position
            kind       <= SCAN_POS;
            issue_pos  <= '0;
            issue_done <= 1'b0;
          end
        end
        S_SH_WR: sh_pos <= sh_pos - 1'b1;
        default: ;
      endcase
    end
  end

  // Memories are stable while a scan walks them
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!ent_we && !rec_we))
    else $error("memory written during scan");

  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_WR) |-> (sh_pos != '0))
    else $error("shift pointer reached head");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("compare stage valid without a list read");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state != S_IDLE))
    else $error("accepted request not started");

  a_nofree_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == STAT_NOFREE) |->
    (out_res.result_index == 5'd0 && !out_res.hit && out_res.disk_request == DREQ_NONE))
    else $error("no-free result carries a buffer");

endmodule

### sv/lru_block_buffer_cache_unit.sv
// LRU block buffer cache: tag, reference count and recency manager for a
// pool of NUM_BUFFERS disk block buffers.
//
// Channels: req (sink) takes mode, device, block_number and buffer_index;
// res (source) returns result_index, hit, disk_request and status. Both use
// valid/ready; a request moves at a clock edge with both high. Exactly one
// result is returned per request, in order.
//
// Timing: one request at a time, ready only when the sequencer is idle.
// An acquire walks the list from the head until a tag hit; a miss then
// walks it again from the tail for a free buffer. Release to a zero count
// searches the list for the buffer and shifts it to the head.
//
// Reset: synchronous rst starts a clearing pass that zeroes tags and counts
// and rebuilds the recency list; req is not ready during it.
//
// Stall: a finished result sits in the output register; the next request
// is still taken and worked, and only its result waits for the register.
module lru_block_buffer_cache_unit #(
  parameter int NUM_BUFFERS = lbc_pkg::NUM_BUFFERS_DEF
) (
  input logic        clk,
  input logic        rst,
  lbc_req_if.sink    req,
  lbc_res_if.source  res
);
  import lbc_pkg::*;

  lbc_req_t in_req;
  lbc_res_t ctrl_res, res_q;
  logic     in_ready, ctrl_valid, ctrl_ready, res_valid;

  assign in_req.mode         = req.mode;
  assign in_req.device       = req.device;
  assign in_req.block_number = req.block_number;
  assign in_req.buffer_index = req.buffer_index;
  assign req.ready           = in_ready;

  lbc_ctrl #(.NUM_BUFFERS(NUM_BUFFERS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (ctrl_valid),
    .out_ready (ctrl_ready),
    .out_res   (ctrl_res)
  );

  // Output register: loads when empty or being drained
  assign ctrl_ready = !res_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl_ready) begin
      res_valid <= ctrl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_valid && ctrl_ready) res_q <= ctrl_res;
  end

  assign res.valid        = res_valid;
  assign res.result_index = res_q.result_index;
  assign res.hit          = res_q.hit;
  assign res.disk_request = res_q.disk_request;
  assign res.status       = res_q.status;

endmodule
